[hw/rtl/ksmr_pkg.sv]
// ksmr_pkg: shared codes, field widths and the case-folding helper for the keyed stack
// used by the channel interfaces and the top level; depends on nothing
package ksmr_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_IN_W = 64;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 3;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [STAMP_W-1:0]  stamp_t;

    localparam mode_t MODE_PUSH   = 2'd0;
    localparam mode_t MODE_REMOVE = 2'd1;
    localparam mode_t MODE_SEARCH = 2'd2;
    localparam mode_t MODE_NOP    = 2'd3;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_EMPTY_KEY   = 3'd1;
    localparam status_t ST_DUP         = 3'd2;
    localparam status_t ST_FULL        = 3'd3;
    localparam status_t ST_STORE_EMPTY = 3'd4;
    localparam status_t ST_NOT_FOUND   = 3'd5;

    // lower-case ascii letter to upper case, every other byte kept
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

[hw/rtl/ksmr_req_if.sv]
// ksmr_req_if: request channel of the keyed stack (valid/ready plus mode, key and stamp)
// depends on ksmr_pkg
interface ksmr_req_if;
    logic                    valid;
    logic                    ready;
    ksmr_pkg::mode_t         mode;
    logic [ksmr_pkg::KEY_IN_W-1:0] key;
    ksmr_pkg::stamp_t        stamp;

    modport source (output valid, output mode, output key, output stamp, input ready);
    modport sink   (input valid, input mode, input key, input stamp, output ready);
endinterface

[hw/rtl/ksmr_rsp_if.sv]
// ksmr_rsp_if: response channel of the keyed stack (valid/ready plus status, position,
// stamp and count); depends on ksmr_pkg
interface ksmr_rsp_if #(
    parameter int CNT_W = 7
);
    logic               valid;
    logic               ready;
    ksmr_pkg::status_t  status;
    logic [CNT_W-1:0]   position;
    ksmr_pkg::stamp_t   found_stamp;
    logic [CNT_W-1:0]   count;

    modport source (output valid, output status, output position, output found_stamp,
                    output count, input ready);
    modport sink   (input valid, input status, input position, input found_stamp,
                    input count, output ready);
endinterface

[hw/rtl/ksmr_ram.sv]
// ksmr_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
module ksmr_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/keyed_stack_with_middle_removal_top.sv]
// keyed_stack_with_middle_removal_top: lifo of unique upper-cased keys with timestamps,
// search and removal from any depth; depends on ksmr_pkg, ksmr_req_if, ksmr_rsp_if, ksmr_ram
//
//   port  dir  word carries
//   ----  ---  --------------------------------------------
//   req   in   mode, key (64 bits), stamp (32 bits)
//   rsp   out  status, position, found_stamp, count
//
// one ram holds key and stamp, entry 0 the bottom; a scan reads one entry a cycle from the top
// a new push or a miss scans every entry, a hit stops the scan at the match, and a remove below
// the top then moves every entry above the match down one place
// empty key, empty store and the unused mode skip the scan
// reset clears the fill count and control only; ram contents are never cleared
// the next word is taken while a result waits; a later result stalls until rsp drains it
module keyed_stack_with_middle_removal_top #(
    parameter int DEPTH     = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    ksmr_req_if.sink   req,
    ksmr_rsp_if.source rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int DW    = KEY_W + ksmr_pkg::STAMP_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [CW-1:0]          fill_reg, fill_next;
    ksmr_pkg::mode_t        mode_reg, mode_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    ksmr_pkg::stamp_t       stamp_reg, stamp_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic                   issue_reg, issue_next;
    logic                   dv_reg, dv_next;
    logic [AW-1:0]          di_reg, di_next;

    ksmr_pkg::status_t      res_status_reg, res_status_next;
    logic [CW-1:0]          res_pos_reg, res_pos_next;
    ksmr_pkg::stamp_t       res_stamp_reg, res_stamp_next;

    logic                   out_vld_reg, out_vld_next;
    ksmr_pkg::status_t      out_status_reg, out_status_next;
    logic [CW-1:0]          out_pos_reg, out_pos_next;
    ksmr_pkg::stamp_t       out_stamp_reg, out_stamp_next;
    logic [CW-1:0]          out_count_reg, out_count_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [DW-1:0]          ram_wdata, ram_rdata;
    logic [KEY_W-1:0]       key_fold;
    logic [KEY_W-1:0]       rd_key;
    ksmr_pkg::stamp_t       rd_stamp;
    logic [AW-1:0]          top_idx;
    logic                   accept;
    logic                   match;

    genvar b;
    generate
        for (b = 0; b < KEY_BYTES; b++)
        begin : g_fold
            assign key_fold[8*b +: 8] = ksmr_pkg::fold_byte(req.key[8*b +: 8]);
        end
    endgenerate

    ksmr_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[DW-1 -: KEY_W];
    assign rd_stamp = ram_rdata[ksmr_pkg::STAMP_W-1:0];
    assign top_idx  = AW'(fill_reg - CW'(1));
    assign accept   = req.valid && req.ready;
    assign match    = dv_reg && (rd_key == key_reg);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.position    = out_pos_reg;
    assign rsp.found_stamp = out_stamp_reg;
    assign rsp.count       = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        stamp_next      = stamp_reg;
        ptr_next        = ptr_reg;
        issue_next      = issue_reg;
        dv_next         = 1'b0;
        di_next         = di_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_stamp_next  = res_stamp_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_stamp_next  = out_stamp_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = {key_reg, stamp_reg};
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = req.mode;
                    key_next        = key_fold;
                    stamp_next      = req.stamp;
                    res_status_next = ksmr_pkg::ST_OK;
                    res_pos_next    = '0;
                    res_stamp_next  = '0;
                    if (req.mode == ksmr_pkg::MODE_NOP)
                    begin
                        state_next = S_DONE;
                    end
                    else if (req.mode == ksmr_pkg::MODE_PUSH && key_fold == '0)
                    begin
                        res_status_next = ksmr_pkg::ST_EMPTY_KEY;
                        state_next      = S_DONE;
                    end
                    else if (req.mode != ksmr_pkg::MODE_PUSH && fill_reg == '0)
                    begin
                        res_status_next = ksmr_pkg::ST_STORE_EMPTY;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // scan from the top down
                        ptr_next   = top_idx;
                        issue_next = (fill_reg != '0);
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    state_next = S_DONE;
                    if (mode_reg == ksmr_pkg::MODE_PUSH)
                    begin
                        res_status_next = ksmr_pkg::ST_DUP;
                    end
                    else if (mode_reg == ksmr_pkg::MODE_SEARCH)
                    begin
                        res_pos_next   = fill_reg - CW'(di_reg);
                        res_stamp_next = rd_stamp;
                    end
                    else
                    begin
                        res_pos_next = CW'(top_idx - di_reg);
                        if (di_reg == top_idx)
                        begin
                            fill_next = fill_reg - CW'(1);
                        end
                        else
                        begin
                            // move every entry above the match down one place
                            ptr_next   = di_reg + AW'(1);
                            issue_next = 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                end
                else if ((dv_reg && di_reg == '0) || (!dv_reg && !issue_reg))
                begin
                    state_next = S_DONE;
                    if (mode_reg != ksmr_pkg::MODE_PUSH)
                    begin
                        res_status_next = ksmr_pkg::ST_NOT_FOUND;
                    end
                    else if (fill_reg == CW'(DEPTH))
                    begin
                        res_status_next = ksmr_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(fill_reg);
                        fill_next = fill_reg + CW'(1);
                    end
                end
                else
                begin
                    ram_re  = issue_reg;
                    dv_next = issue_reg;
                    di_next = ptr_reg;
                    if (issue_reg)
                    begin
                        if (ptr_reg == '0)
                        begin
                            issue_next = 1'b0;
                        end
                        else
                        begin
                            ptr_next = ptr_reg - AW'(1);
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // read one entry ahead while the previous one is written a place lower
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = di_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (dv_reg && di_reg == top_idx)
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re  = issue_reg;
                    dv_next = issue_reg;
                    di_next = ptr_reg;
                    if (issue_reg)
                    begin
                        if (ptr_reg == top_idx)
                        begin
                            issue_next = 1'b0;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + AW'(1);
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_stamp_next  = res_stamp_reg;
                    out_count_next  = fill_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            issue_reg   <= 1'b0;
            dv_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            issue_reg   <= issue_next;
            dv_reg      <= dv_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        stamp_reg      <= stamp_next;
        ptr_reg        <= ptr_next;
        di_reg         <= di_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_stamp_reg  <= res_stamp_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_stamp_reg  <= out_stamp_next;
        out_count_reg  <= out_count_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write to the same entry in one cycle");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_status_reg == ksmr_pkg::ST_FULL) |-> (out_count_reg == CW'(DEPTH)))
        else $error("full reported below depth");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_pos_reg <= out_count_reg))
        else $error("position beyond count");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (fill_reg > CW'(1)))
        else $error("compaction with too few entries");

endmodule
